// ===== hw/rtl/fks_pkg.sv =====
`default_nettype none
package fks_pkg;

  localparam int unsigned FRAMES_PER_SUPERFRAME_DEF = 18;

  localparam int unsigned ROW_W     = 24;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned HALF_W    = WORD_W / 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned KEY_SZ_W  = 2;
  localparam int unsigned SFC_W     = 64;
  localparam int unsigned POS_FLD_W = 8;

  localparam logic [WORD_W-1:0] SEED_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_1   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_2   = 64'h94D0_49BB_1331_11EB;
  localparam logic [WORD_W-1:0] KEY5_MASK   = 64'h0000_00FF_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_KEY_SIZE = 3'd1,
    CFG_KEY_A    = 3'd2,
    CFG_KEY_B    = 3'd3,
    CFG_KEY_C    = 3'd4,
    CFG_KEY_D    = 3'd5
  } cfg_idx_t;

  typedef enum logic [KEY_SZ_W-1:0] {
    KEY_NONE = 2'd0,
    KEY_5B   = 2'd1,
    KEY_16B  = 2'd2,
    KEY_32B  = 2'd3
  } key_size_t;

  typedef enum logic {
    OP_SCRAMBLE = 1'b0,
    OP_RESET    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_DONE
  } fks_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fks_if.sv =====
`default_nettype none
interface fks_in_if import fks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic             slot;
  logic [ROW_W-1:0] row_a_in;
  logic [ROW_W-1:0] row_b_in;
  logic [ROW_W-1:0] row_c_in;

  modport source (output valid, op, slot, row_a_in, row_b_in, row_c_in, input ready);
  modport sink   (input valid, op, slot, row_a_in, row_b_in, row_c_in, output ready);
endinterface

interface fks_out_if import fks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_a_out;
  logic [ROW_W-1:0] row_b_out;
  logic [ROW_W-1:0] row_c_out;

  modport source (output valid, row_a_out, row_b_out, row_c_out, input ready);
  modport sink   (input valid, row_a_out, row_b_out, row_c_out, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fks_mul64.sv =====
`default_nettype none
// Low 64 bits of a 64 x 64 product from one 32 x 32 multiplier.
// Three partial products are formed on consecutive cycles; the high-by-high
// term never reaches the low word and is skipped.
module fks_mul64 import fks_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] op_a,
  input  wire logic [WORD_W-1:0] op_b,
  output logic      [WORD_W-1:0] result,
  output logic                   done
);

  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [WORD_W-1:0] prod_r, prod_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [HALF_W-1:0] mul_x, mul_y;

  always_comb begin
    unique case (cnt_r)
      2'd0:    begin mul_x = a_r[HALF_W-1:0];      mul_y = b_r[HALF_W-1:0];      end
      2'd1:    begin mul_x = a_r[HALF_W-1:0];      mul_y = b_r[WORD_W-1:HALF_W]; end
      default: begin mul_x = a_r[WORD_W-1:HALF_W]; mul_y = b_r[HALF_W-1:0];      end
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = op_a;
      b_nxt    = op_b;
      cnt_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != 2'd3) begin
        prod_nxt = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
      end
      // Each product registered in prod_r is folded into acc_r in the cycle after.
      if (cnt_r == 2'd1) begin
        acc_nxt = prod_r;
      end else if (cnt_r != 2'd0) begin
        acc_nxt = acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
      end
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign result = acc_r;
  assign done   = done_r;

endmodule
`default_nettype wire

// ===== hw/rtl/frame_keystream_scrambler.sv =====
`default_nettype none
// Channel  Direction  Payload                                   Handshake
// in_ch    in         op, slot, row_a_in, row_b_in, row_c_in    valid / ready
// out_ch   out        row_a_out, row_b_out, row_c_out           valid / ready
// cfg_*    in         cfg_index, cfg_wdata                      cfg_we, no wait
//
// A scramble transaction runs ST_MIX1 and ST_MIX2, then hands its result to the
// output register from ST_DONE. Each of the two finalizer multiplies forms three
// 32 x 32 partial products through the shared multiplier, then the last add.
// Reset ops and pass-through frames go straight to ST_DONE. A result waits in the
// output register while the next transaction runs; one that finds it full stalls.
// Synchronous active-low reset clears state, counters, keys and output valid.
module frame_keystream_scrambler import fks_pkg::*; #(
  parameter int unsigned FRAMES_PER_SUPERFRAME = FRAMES_PER_SUPERFRAME_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  fks_in_if.sink                    in_ch,
  fks_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_wdata
);

  localparam int unsigned POS_W = $clog2(FRAMES_PER_SUPERFRAME);

  fks_state_t        state_r, state_nxt;

  logic              enable_r;
  key_size_t         key_size_r;
  logic [WORD_W-1:0] key_a_r, key_b_r, key_c_r, key_d_r;

  logic [POS_W-1:0]  pos_r [2];
  logic [SFC_W-1:0]  sfc_r [2];
  logic [POS_W-1:0]  pos_nxt [2];
  logic [SFC_W-1:0]  sfc_nxt [2];

  logic              slot_r, slot_nxt;
  logic [ROW_W-1:0]  res_a_r, res_b_r, res_c_r;
  logic [ROW_W-1:0]  res_a_nxt, res_b_nxt, res_c_nxt;
  logic [ROW_W-1:0]  out_a_r, out_b_r, out_c_r;
  logic [ROW_W-1:0]  out_a_nxt, out_b_nxt, out_c_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_fire;
  logic              bypass;
  logic [WORD_W-1:0] fold;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] mix0;
  logic [WORD_W-1:0] mul_a, mul_b, mul_res;
  logic              mul_start, mul_done;
  logic [WORD_W-1:0] r_val;
  logic [POS_W:0]    pos_inc;

  fks_mul64 u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .result (mul_res),
    .done   (mul_done)
  );

  always_comb begin
    unique case (key_size_r)
      KEY_5B:  fold = key_a_r & KEY5_MASK;
      KEY_16B: fold = key_a_r ^ key_b_r;
      KEY_32B: fold = key_a_r ^ key_b_r ^ key_c_r ^ key_d_r;
      default: fold = '0;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign bypass    = !enable_r || (key_size_r == KEY_NONE);
  assign seed_word = SEED_GOLDEN ^ fold
                   ^ {sfc_r[in_ch.slot][SFC_W-POS_FLD_W-1:0],
                      POS_FLD_W'(pos_r[in_ch.slot])};
  assign mix0      = seed_word ^ (seed_word >> 30);
  assign r_val     = mul_res ^ (mul_res >> 31);
  assign pos_inc   = {1'b0, pos_r[slot_r]} + (POS_W+1)'(1);

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    res_a_nxt     = res_a_r;
    res_b_nxt     = res_b_r;
    res_c_nxt     = res_c_r;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_c_nxt     = out_c_r;
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    sfc_nxt       = sfc_r;
    mul_start     = 1'b0;
    mul_a         = mix0;
    mul_b         = MIX_MUL_1;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          slot_nxt  = in_ch.slot;
          res_a_nxt = in_ch.row_a_in;
          res_b_nxt = in_ch.row_b_in;
          res_c_nxt = in_ch.row_c_in;
          if (op_t'(in_ch.op) == OP_RESET) begin
            pos_nxt[in_ch.slot] = '0;
            res_a_nxt = '0;
            res_b_nxt = '0;
            res_c_nxt = '0;
            state_nxt = ST_DONE;
          end else if (bypass) begin
            state_nxt = ST_DONE;
          end else begin
            mul_start = 1'b1;
            state_nxt = ST_MIX1;
          end
        end
      end
      ST_MIX1: begin
        mul_a = mul_res ^ (mul_res >> 27);
        mul_b = MIX_MUL_2;
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = ST_MIX2;
        end
      end
      ST_MIX2: begin
        if (mul_done) begin
          res_a_nxt = res_a_r ^ r_val[63:40];
          res_b_nxt = res_b_r ^ r_val[39:16];
          res_c_nxt = res_c_r ^ {r_val[15:0], r_val[63:56]};
          if (pos_inc >= (POS_W+1)'(FRAMES_PER_SUPERFRAME)) begin
            pos_nxt[slot_r] = '0;
            sfc_nxt[slot_r] = sfc_r[slot_r] + SFC_W'(1);
          end else begin
            pos_nxt[slot_r] = pos_inc[POS_W-1:0];
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand over once the output register is free or being drained.
        if (!out_valid_r || out_ch.ready) begin
          out_a_nxt     = res_a_r;
          out_b_nxt     = res_b_r;
          out_c_nxt     = res_c_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '{default: '0};
      sfc_r       <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      sfc_r       <= sfc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b1;
      key_size_r <= KEY_NONE;
      key_a_r    <= '0;
      key_b_r    <= '0;
      key_c_r    <= '0;
      key_d_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:   enable_r   <= cfg_wdata[0];
        CFG_KEY_SIZE: key_size_r <= key_size_t'(cfg_wdata[KEY_SZ_W-1:0]);
        CFG_KEY_A:    key_a_r    <= cfg_wdata;
        CFG_KEY_B:    key_b_r    <= cfg_wdata;
        CFG_KEY_C:    key_c_r    <= cfg_wdata;
        CFG_KEY_D:    key_d_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    res_a_r <= res_a_nxt;
    res_b_r <= res_b_nxt;
    res_c_r <= res_c_nxt;
    out_a_r <= out_a_nxt;
    out_b_r <= out_b_nxt;
    out_c_r <= out_c_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_a_out = out_a_r;
  assign out_ch.row_b_out = out_b_r;
  assign out_ch.row_c_out = out_c_r;

endmodule
`default_nettype wire
